### sv/flmr_pkg.sv
// shared types and constants for the four-lane multiply-rotate hash core
// no dependencies
`timescale 1ns / 1ps

package flmr_pkg;

    localparam int LengthBits = 32;

    localparam logic [63:0] HASH_G  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_M1 = 64'h85EBCA77C2B2AE3D;
    localparam logic [63:0] HASH_M2 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] HASH_M3 = 64'h94D049BB133111EB;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    // command kinds handed from front to back
    localparam logic [1:0] CMD_SEED   = 2'd0;
    localparam logic [1:0] CMD_ABSORB = 2'd1;
    localparam logic [1:0] CMD_SEED_FIN = 2'd2;
    localparam logic [1:0] CMD_ABS_FIN  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  lane;
        logic [63:0] value;
        logic [63:0] base;
    } flmr_cmd_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
        logic [127:0] d;
        begin
            d = {v, v} << r;
            rotl64 = d[127:64];
        end
    endfunction

    function automatic logic [5:0] lane_rot(input logic [1:0] lane);
        logic [5:0] r;
        begin
            unique case (lane)
                2'd0: r = 6'd23;
                2'd1: r = 6'd47;
                2'd2: r = 6'd13;
                default: r = 6'd37;
            endcase
            lane_rot = r;
        end
    endfunction

endpackage

### sv/four_lane_multiply_rotate_hash64_core.sv
// top level of the four-lane multiply-rotate 64-bit hash core
// depends on flmr_pkg, flmr_front, flmr_queue, flmr_back
`timescale 1ns / 1ps

// A start beat (func 0) carries seed and byte length; data beats (func 1) carry
// little-endian 64-bit words, and one hash beat leaves after the word that ends
// the message, or right after a zero-length start. Every 64-bit multiply runs
// on one shared 32x32 multiplier. A data word in the back end takes a load
// plus one multiply, a start takes a load, a base multiply and four seed
// multiplies, and the finalizer adds a fold, three multiplies and an output
// on the last item. The front end accepts beats into a two-entry queue, so it
// runs ahead while the multiplier is busy or a hash waits.
module four_lane_multiply_rotate_hash64_core
    import flmr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // seed[63:0], message_length[95:64], data_word[159:96]
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // hash_value
);

    logic      q_valid, q_ready, b_valid, b_ready;
    flmr_cmd_t q_cmd, b_cmd;

    flmr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .func           (s_tuser),
        .seed           (s_tdata[63:0]),
        .message_length (s_tdata[95:64]),
        .data_word      (s_tdata[159:96]),
        .cmd_valid      (q_valid),
        .cmd_ready      (q_ready),
        .cmd            (q_cmd)
    );

    flmr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_valid),
        .wr_ready (q_ready),
        .wr_cmd   (q_cmd),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_cmd   (b_cmd)
    );

    flmr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (b_valid),
        .cmd_ready  (b_ready),
        .cmd        (b_cmd),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .hash_value (m_tdata)
    );

`ifndef SYNTHESIS
    // the front never issues a command the queue cannot hold
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> q_ready)
        else $error("command lost at queue");

    // a waiting hash holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("hash changed while stalled");

    // a command taken by the back end leaves it busy, not ready for another
    a_back_take: assert property (@(posedge clk) disable iff (!rst_n)
        (b_ready && b_valid) |=> !b_ready)
        else $error("back end accepted while busy");
`endif

endmodule

### sv/flmr_front.sv
// front part: accepts items, tracks lengths, issues absorb and seed commands
// depends on flmr_pkg
`timescale 1ns / 1ps

module flmr_front
    import flmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [63:0] seed,
    input  logic [31:0] message_length,
    input  logic [63:0] data_word,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output flmr_cmd_t   cmd
);

    logic [LengthBits-1:0] bytes_reg, bytes_next;
    logic [LengthBits-1:0] block_reg, block_next;
    logic [1:0]            lane_reg, lane_next;
    logic                  active_reg, active_next;
    logic [LengthBits-1:0] len;
    logic [63:0]           len64;
    logic [63:0]           mask;
    logic [2:0]            nb;
    logic                  fire;

    assign in_ready = cmd_ready;
    assign fire     = in_valid && cmd_ready;
    assign len      = LengthBits'(message_length);
    assign len64    = 64'(len);
    assign nb       = bytes_reg[2:0];
    assign mask     = (64'd1 << {nb, 3'b000}) - 64'd1;

    // classify the beat and build a command
    always_comb
    begin
        bytes_next  = bytes_reg;
        block_next  = block_reg;
        lane_next   = lane_reg;
        active_next = active_reg;
        cmd_valid   = 1'b0;
        cmd         = '0;
        if (fire)
        begin
            if (func == FUNC_START)
            begin
                cmd_valid  = 1'b1;
                cmd.kind   = (len == '0) ? CMD_SEED_FIN : CMD_SEED;
                cmd.value  = len64;
                cmd.base   = seed;
                bytes_next = len;
                block_next = len & ~LengthBits'(31);
                lane_next  = 2'd0;
                active_next = (len != '0);
            end
            else if (active_reg)
            begin
                cmd_valid = 1'b1;
                cmd.value = data_word;
                if (block_reg >= LengthBits'(8))
                begin
                    cmd.lane   = lane_reg;
                    lane_next  = lane_reg + 2'd1;
                    block_next = block_reg - LengthBits'(8);
                    bytes_next = bytes_reg - LengthBits'(8);
                end
                else if (bytes_reg >= LengthBits'(8))
                begin
                    bytes_next = bytes_reg - LengthBits'(8);
                end
                else
                begin
                    cmd.value  = data_word & mask;
                    bytes_next = '0;
                end
                cmd.kind    = (bytes_next == '0) ? CMD_ABS_FIN : CMD_ABSORB;
                active_next = (bytes_next != '0);
            end
        end
    end

    // length tracking registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg  <= '0;
            block_reg  <= '0;
            lane_reg   <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            bytes_reg  <= bytes_next;
            block_reg  <= block_next;
            lane_reg   <= lane_next;
            active_reg <= active_next;
        end
    end

endmodule

### sv/flmr_queue.sv
// two-entry command queue between front and back
// depends on flmr_pkg
`timescale 1ns / 1ps

module flmr_queue
    import flmr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  flmr_cmd_t wr_cmd,
    output logic      rd_valid,
    input  logic      rd_ready,
    output flmr_cmd_t rd_cmd
);

    flmr_cmd_t mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_cmd   = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_rd)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

### sv/flmr_back.sv
// back part: lane accumulators, 64-bit multiply built on a shared 32x32 multiplier,
// finalizer, output register; depends on flmr_pkg
`timescale 1ns / 1ps

module flmr_back
    import flmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  flmr_cmd_t   cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_value
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BASE  = 4'd1;
    localparam logic [3:0] ST_SEED  = 4'd2;
    localparam logic [3:0] ST_ABS   = 4'd3;
    localparam logic [3:0] ST_FOLD  = 4'd4;
    localparam logic [3:0] ST_FIN   = 4'd5;
    localparam logic [3:0] ST_EMIT  = 4'd6;

    logic [3:0]  state_reg, state_next;
    logic [63:0] lanes_reg [4];
    logic [63:0] lanes_next [4];
    logic [63:0] x_reg, x_next;
    logic [1:0]  idx_reg, idx_next;
    logic [1:0]  lane_reg, lane_next;
    logic        fin_reg, fin_next;
    logic [63:0] ma, mb, prod;
    logic [1:0]  ph_reg, ph_next;
    logic [63:0] acc_reg;
    logic [31:0] mul_x, mul_y;
    logic [63:0] pp, term;
    logic [1:0]  step_reg, step_next;
    logic [63:0] out_reg, out_next;
    logic        ov_reg, ov_next;
    logic [63:0] fs;

    assign out_valid  = ov_reg;
    assign hash_value = out_reg;
    assign cmd_ready  = (state_reg == ST_IDLE);

    // low 64 bits of ma * mb in three passes: lo*lo, hi*lo, lo*hi
    always_comb
    begin
        unique case (ph_reg)
            2'd0:
            begin
                mul_x = ma[31:0];
                mul_y = mb[31:0];
            end
            2'd1:
            begin
                mul_x = ma[63:32];
                mul_y = mb[31:0];
            end
            default:
            begin
                mul_x = ma[31:0];
                mul_y = mb[63:32];
            end
        endcase
    end

    assign pp   = {32'd0, mul_x} * {32'd0, mul_y};
    assign term = (ph_reg == 2'd0) ? pp : {pp[31:0], 32'd0};
    assign prod = ((ph_reg == 2'd0) ? 64'd0 : acc_reg) + term;

    // finalizer shift per step
    always_comb
    begin
        unique case (step_reg)
            2'd0: fs = x_reg ^ (x_reg >> 29);
            2'd1: fs = x_reg ^ (x_reg >> 31);
            default: fs = x_reg ^ (x_reg >> 37);
        endcase
    end

    // sequencer: seeding, absorbing, finalizing and output
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        idx_next   = idx_reg;
        lane_next  = lane_reg;
        fin_next   = fin_reg;
        step_next  = step_reg;
        out_next   = out_reg;
        ov_next    = ov_reg;
        ph_next    = ph_reg;
        lanes_next = lanes_reg;
        ma = x_reg;
        mb = HASH_G;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    fin_next = (cmd.kind == CMD_SEED_FIN) || (cmd.kind == CMD_ABS_FIN);
                    if ((cmd.kind == CMD_SEED) || (cmd.kind == CMD_SEED_FIN))
                    begin
                        x_next     = cmd.base;
                        lanes_next[0] = cmd.value;
                        state_next = ST_BASE;
                    end
                    else
                    begin
                        lane_next  = cmd.lane;
                        x_next     = lanes_reg[cmd.lane] ^ rotl64(cmd.value, lane_rot(cmd.lane));
                        state_next = ST_ABS;
                    end
                end
            end
            ST_BASE:
            begin
                ma = lanes_reg[0];
                if (ph_reg == 2'd2)
                begin
                    ph_next    = 2'd0;
                    x_next     = x_reg ^ prod;
                    idx_next   = 2'd0;
                    state_next = ST_SEED;
                end
                else
                begin
                    ph_next = ph_reg + 2'd1;
                end
            end
            ST_SEED:
            begin
                unique case (idx_reg)
                    2'd0: mb = HASH_G;
                    2'd1: mb = HASH_M1;
                    2'd2: mb = HASH_M2;
                    default: mb = HASH_M3;
                endcase
                if (ph_reg == 2'd2)
                begin
                    ph_next = 2'd0;
                    lanes_next[idx_reg] = prod;
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        state_next = fin_reg ? ST_FOLD : ST_IDLE;
                    end
                end
                else
                begin
                    ph_next = ph_reg + 2'd1;
                end
            end
            ST_ABS:
            begin
                if (ph_reg == 2'd2)
                begin
                    ph_next = 2'd0;
                    lanes_next[lane_reg] = prod;
                    state_next = fin_reg ? ST_FOLD : ST_IDLE;
                end
                else
                begin
                    ph_next = ph_reg + 2'd1;
                end
            end
            ST_FOLD:
            begin
                x_next = lanes_reg[0] ^ lanes_reg[1] ^ lanes_reg[2] ^ lanes_reg[3];
                step_next  = 2'd0;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                ma = fs;
                unique case (step_reg)
                    2'd0: mb = HASH_M1;
                    2'd1: mb = HASH_M2;
                    default: mb = HASH_G;
                endcase
                if (ph_reg == 2'd2)
                begin
                    ph_next   = 2'd0;
                    x_next    = prod;
                    step_next = step_reg + 2'd1;
                    if (step_reg == 2'd2)
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    ph_next = ph_reg + 2'd1;
                end
            end
            ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    out_next   = x_reg ^ (x_reg >> 41);
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        lane_reg  <= lane_next;
        out_reg   <= out_next;
        idx_reg   <= idx_next;
        step_reg  <= step_next;
        acc_reg   <= prod;
    end

    // control and lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            ph_reg    <= 2'd0;
            for (int i = 0; i < 4; i++)
            begin
                lanes_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            ov_reg    <= ov_next;
            ph_reg    <= ph_next;
            lanes_reg <= lanes_next;
        end
    end

endmodule
